### rtl/slip_pkg.sv
`timescale 1ns / 1ps

package slip_pkg;

    localparam logic [7:0] END_CODE     = 8'hC0;
    localparam logic [7:0] ESC_CODE     = 8'hDB;
    localparam logic [7:0] ESC_END_CODE = 8'hDC;
    localparam logic [7:0] ESC_ESC_CODE = 8'hDD;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       last;
    } result_t;

    // Results produced by one decoded byte: zero, one or two.
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

### rtl/slip_decode.sv
`timescale 1ns / 1ps

module slip_decode #(
    parameter int MAX_FRAME_LEN = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    input  logic                space_ok,
    output slip_pkg::push_t     push
);
    import slip_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_LEN + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME_LEN);

    logic          valid_reg;
    logic [7:0]    byte_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          esc_reg, esc_next;
    logic          fire;
    push_t         res;

    assign fire    = valid_reg && space_ok;
    assign s_ready = !valid_reg || fire;

    // Hold the byte until the result queue has room for two results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            esc_reg   <= 1'b0;
        end else if (fire) begin
            count_reg <= count_next;
            esc_reg   <= esc_next;
        end
    end

    always_comb begin
        res        = '0;
        count_next = count_reg;
        esc_next   = esc_reg;
        priority if (byte_reg == END_CODE) begin
            esc_next = 1'b0;
            if (count_reg != '0) begin
                count_next = '0;
                if (esc_reg) begin
                    res.cnt = 2'd2;
                    res.r0  = '{kind: KIND_DATA, data_byte: ESC_CODE, last: 1'b0};
                    res.r1  = '{kind: KIND_END, data_byte: 8'h00, last: 1'b1};
                end else begin
                    res.cnt = 2'd1;
                    res.r0  = '{kind: KIND_END, data_byte: 8'h00, last: 1'b1};
                end
            end
        end else if (count_reg >= MAX_CNT) begin
            // Drop the byte and any pending escape, abort the frame.
            res.cnt    = 2'd1;
            res.r0     = '{kind: KIND_ABORT, data_byte: 8'h00, last: 1'b1};
            count_next = '0;
            esc_next   = 1'b0;
        end else if (esc_reg) begin
            priority if (byte_reg == ESC_END_CODE) begin
                res.cnt  = 2'd1;
                res.r0   = '{kind: KIND_DATA, data_byte: END_CODE, last: 1'b1};
                esc_next = 1'b0;
            end else if (byte_reg == ESC_ESC_CODE) begin
                res.cnt  = 2'd1;
                res.r0   = '{kind: KIND_DATA, data_byte: ESC_CODE, last: 1'b1};
                esc_next = 1'b0;
            end else if (byte_reg == ESC_CODE) begin
                res.cnt    = 2'd1;
                res.r0     = '{kind: KIND_DATA, data_byte: ESC_CODE, last: 1'b1};
                count_next = count_reg + CW'(1);
                esc_next   = 1'b1;
            end else begin
                res.cnt    = 2'd2;
                res.r0     = '{kind: KIND_DATA, data_byte: ESC_CODE, last: 1'b0};
                res.r1     = '{kind: KIND_DATA, data_byte: byte_reg, last: 1'b1};
                count_next = count_reg + CW'(1);
                esc_next   = 1'b0;
            end
        end else if (byte_reg == ESC_CODE) begin
            esc_next   = 1'b1;
            count_next = count_reg + CW'(1);
        end else begin
            res.cnt    = 2'd1;
            res.r0     = '{kind: KIND_DATA, data_byte: byte_reg, last: 1'b1};
            count_next = count_reg + CW'(1);
        end
    end

    always_comb begin
        push = res;
        if (!fire) begin
            push.cnt = 2'd0;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT)
        else $error("frame count above limit");

    a_esc_has_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> count_reg != '0)
        else $error("pending escape without a slot");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> count_reg == '0 && !esc_reg && !valid_reg)
        else $error("decoder state not cleared by reset");

endmodule

### rtl/slip_result_fifo.sv
`timescale 1ns / 1ps

module slip_result_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  slip_pkg::push_t     push,
    output logic                space_ok,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic [7:0]          m_data_byte,
    output logic                m_last
);
    import slip_pkg::*;

    localparam int DEPTH = 4;

    result_t    mem [DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg, count_next;
    logic       pop;
    result_t    head;

    assign head        = mem[rd_ptr_reg];
    assign m_valid     = count_reg != 3'd0;
    assign m_kind      = head.kind;
    assign m_data_byte = head.data_byte;
    assign m_last      = head.last;
    assign pop         = m_valid && m_ready;
    assign space_ok    = count_reg <= 3'(DEPTH - 2);
    assign count_next  = count_reg + {1'b0, push.cnt} - {2'b00, pop};

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            mem[wr_ptr_reg + 2'd1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push.cnt;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(DEPTH))
        else $error("result queue overflow");

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        push.cnt != 2'd0 |-> space_ok)
        else $error("push without room");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == 3'd0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("pointers disagree on empty queue");

endmodule

### rtl/slip_frame_decoder_core.sv
`timescale 1ns / 1ps
// Accepted bytes are registered in the decode stage; their results go to the result queue.
// Throughput: one byte per cycle unless stalled; both results of a two-result byte are
// absorbed by the four-entry result queue; input stalls while it holds three or more.
// The output port delivers at most one result per cycle, which sets the sustained rate.
// Reset: synchronous active-low aresetn clears frame count, escape flag, pending byte and queue.

module slip_frame_decoder_core #(
    parameter int MAX_FRAME_LEN = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic       m_last
);
    import slip_pkg::*;

    push_t push;
    logic  space_ok;

    // Decode stage: register the request, strip framing, update frame state.
    slip_decode #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .space_ok  (space_ok),
        .push      (push)
    );

    // Result queue: accept up to two results per cycle, drain one per cycle while m_ready is high.
    slip_result_fifo u_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .space_ok    (space_ok),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_data_byte (m_data_byte),
        .m_last      (m_last)
    );

endmodule
